// ===== rtl/core/kef_pkg.sv =====
// ----------------------------------------------------------------------------
// kef_pkg
// Shared types and constants for the scalar Kalman event fuser: request
// payload structs, fixed-point constants and register indexes.
// ----------------------------------------------------------------------------
package kef_pkg;

	// Fixed-point format and field widths
	localparam int FRAC     = 16;
	localparam int STAMP_W  = 48;
	localparam int NOISE_W  = 20;
	localparam int READ_W   = 32;
	localparam int POS_W    = 25;
	localparam int UNC_W    = 17;
	localparam int PN_W     = 16;
	localparam int P_W      = 18;
	localparam int DEN_W    = 21;
	localparam int K_W      = 17;
	localparam int CFG_W    = 20;
	localparam int CFG_IDX_W = 2;

	// Shared multiplier operand and product widths
	localparam int MA_W = 42;
	localparam int MB_W = 18;
	localparam int MP_W = MA_W + MB_W;
	localparam int ACC_W = 64;

	// Constants of the update math
	localparam logic [UNC_W-1:0] ONE_U     = 17'd65536;
	localparam logic [UNC_W-1:0] UNC_MAX   = 17'd131071;
	localparam logic [UNC_W-1:0] UNC_RESET = 17'd65536;
	localparam logic [31:0]      EPS       = 32'd655;

	// Reciprocals for floor division: M = ceil(2^35 / d), split in halves
	localparam int RECIP_SH = 35;
	localparam logic [15:0] R12_LO = 16'hAAAB;
	localparam logic [15:0] R12_HI = 16'hAAAA;
	localparam logic [15:0] R10_LO = 16'hCCCD;
	localparam logic [15:0] R10_HI = 16'hCCCC;

	// Register reset values
	localparam logic [PN_W-1:0]    PN_RESET = 16'd328;
	localparam logic [NOISE_W-1:0] DN_RESET = 20'd32768;

	// Register indexes
	localparam logic [CFG_IDX_W-1:0] REG_PROCESS_NOISE = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_INIT_UNCERT   = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_DEFAULT_NOISE = 2'd2;

	typedef struct packed {
		logic [STAMP_W-1:0] stamp_ms;
		logic               has_noise;
		logic [NOISE_W-1:0] noise;
		logic               has_mag;
		logic [READ_W-1:0]  mag_reading;
		logic               has_mmi;
		logic [READ_W-1:0]  mmi_reading;
		logic               has_position;
		logic [POS_W-1:0]   lat_reading;
		logic [POS_W-1:0]   lon_reading;
	} in_t;

	typedef struct packed {
		logic [READ_W-1:0] mag_estimate;
		logic [READ_W-1:0] mmi_estimate;
		logic [POS_W-1:0]  lat_estimate;
		logic [POS_W-1:0]  lon_estimate;
		logic [UNC_W-1:0]  uncertainty_out;
		logic [UNC_W-1:0]  severity_score;
		logic              late_flag;
	} out_t;

endpackage

// ===== rtl/core/kef_div.sv =====
// ----------------------------------------------------------------------------
// kef_div
// Serial restoring divider for the Kalman gain K = floor(P * ONE / den),
// one quotient bit per cycle.
// ----------------------------------------------------------------------------
module kef_div (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      start,
	input  logic [kef_pkg::P_W-1:0]   num,
	input  logic [kef_pkg::DEN_W-1:0] den,
	output logic                      done,
	output logic [kef_pkg::K_W-1:0]   quo
);
	import kef_pkg::*;

	logic [DEN_W-1:0] rem_q;
	logic [K_W-1:0]   quo_q;
	logic [4:0]       cnt_q;
	logic             busy_q;
	logic             done_q;
	logic [DEN_W:0]   rem2;
	logic             take;

	// Shift the remainder and trial-subtract the divisor
	assign rem2 = {rem_q, 1'b0};
	assign take = (rem2 >= {1'b0, den});

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
			rem_q  <= '0;
			quo_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				if (den == '0) begin
					quo_q  <= '0;
					done_q <= 1'b1;
				end else if ({3'b0, num} >= den) begin
					quo_q  <= K_W'(1);
					rem_q  <= DEN_W'({3'b0, num} - den);
					cnt_q  <= 5'(FRAC);
					busy_q <= 1'b1;
				end else begin
					quo_q  <= '0;
					rem_q  <= {3'b0, num};
					cnt_q  <= 5'(FRAC);
					busy_q <= 1'b1;
				end
			end else if (busy_q) begin
				// Advance one quotient bit
				rem_q <= take ? DEN_W'(rem2 - {1'b0, den}) : rem2[DEN_W-1:0];
				quo_q <= {quo_q[K_W-2:0], take};
				cnt_q <= cnt_q - 5'd1;
				if (cnt_q == 5'd1) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	assign done = done_q;
	assign quo  = quo_q;

endmodule

// ===== rtl/core/scalar_kalman_event_fuser_top.sv =====
// Only one request is in work at a time, and its pace is set by the 17-step
// gain divider and the single 42x18 multiplier that serves every product in turn.
// The result sits in an output register, so the next request is taken while it waits;
// a finished request waits in its last step while that register is still held.
// Reset: estimates and latest stamp clear, uncertainty loads 1.0, registers load defaults.
// ----------------------------------------------------------------------------
// scalar_kalman_event_fuser_top
// Scalar Kalman fuser: gain from predicted uncertainty and noise, blend of
// each present estimate, uncertainty update and saturated severity score.
// ----------------------------------------------------------------------------
module scalar_kalman_event_fuser_top (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          in_valid,
	output logic                          in_stall,
	input  kef_pkg::in_t                  in_item,
	output logic                          out_valid,
	input  logic                          out_stall,
	output kef_pkg::out_t                 out_item,
	input  logic                          cfg_we,
	input  logic [kef_pkg::CFG_IDX_W-1:0] cfg_idx,
	input  logic [kef_pkg::CFG_W-1:0]     cfg_wdata
);
	import kef_pkg::*;

	typedef enum logic [4:0] {
		ST_IDLE, ST_DIV_GO, ST_DIV,
		ST_MAG_M, ST_MAG_A, ST_MMI_M, ST_MMI_A,
		ST_LAT_M, ST_LAT_A, ST_LON_M, ST_LON_A,
		ST_UNC_M, ST_UNC_A,
		ST_Q12L_M, ST_Q12L_A, ST_Q12H_M, ST_Q12H_A, ST_Q12_FIX,
		ST_Q10L_M, ST_Q10L_A, ST_Q10H_M, ST_Q10H_A, ST_Q10_FIX,
		ST_ABL_M, ST_ABL_A, ST_ABH_M, ST_ABH_A,
		ST_SC_M, ST_SC_A, ST_OUT
	} state_t;

	state_t state_q;

	// Registers
	logic [PN_W-1:0]    pn_q;
	logic [NOISE_W-1:0] dn_q;

	// Filter state
	logic signed [READ_W-1:0] mag_est_q, mmi_est_q;
	logic signed [POS_W-1:0]  lat_est_q, lon_est_q;
	logic [UNC_W-1:0]         uncert_q;
	logic [STAMP_W-1:0]       latest_q;
	logic                     seen_q;

	// Working registers
	in_t                      item_q;
	logic                     late_q;
	logic [P_W-1:0]           p_q;
	logic [DEN_W-1:0]         den_q;
	logic [K_W-1:0]           k_q;
	logic signed [MP_W-1:0]   prod_q;
	logic signed [ACC_W-1:0]  acc_q;
	logic signed [31:0]       a_q, b_q;
	logic signed [MA_W-1:0]   sev_q;
	logic [UNC_W-1:0]         score_q;
	out_t                     out_q;
	logic                     out_valid_q;

	// Divider
	logic             div_done;
	logic [K_W-1:0]   div_quo;

	kef_div u_div (
		.clk   (clk),
		.arst_n(arst_n),
		.start (state_q == ST_DIV_GO),
		.num   (p_q),
		.den   (den_q),
		.done  (div_done),
		.quo   (div_quo)
	);

	// Differences toward each reading
	logic signed [READ_W:0] dmag, dmmi;
	logic signed [POS_W:0]  dlat, dlon;
	assign dmag = (READ_W+1)'($signed(item_q.mag_reading)) - (READ_W+1)'(mag_est_q);
	assign dmmi = (READ_W+1)'($signed(item_q.mmi_reading)) - (READ_W+1)'(mmi_est_q);
	assign dlat = (POS_W+1)'($signed(item_q.lat_reading)) - (POS_W+1)'(lat_est_q);
	assign dlon = (POS_W+1)'($signed(item_q.lon_reading)) - (POS_W+1)'(lon_est_q);

	// Confidence from the updated uncertainty
	logic signed [MB_W-1:0] conf;
	assign conf = (uncert_q >= ONE_U) ? '0 : MB_W'(ONE_U - uncert_q);

	// Gain complement
	logic [K_W-1:0] k_c;
	assign k_c = ONE_U - k_q;

	// Shared multiplier operand select
	logic signed [MA_W-1:0] ma;
	logic signed [MB_W-1:0] mb;
	always_comb begin
		ma = '0;
		mb = '0;
		case (state_q)
			ST_MAG_M:  begin ma = MA_W'(dmag); mb = {1'b0, k_q}; end
			ST_MMI_M:  begin ma = MA_W'(dmmi); mb = {1'b0, k_q}; end
			ST_LAT_M:  begin ma = MA_W'(dlat); mb = {1'b0, k_q}; end
			ST_LON_M:  begin ma = MA_W'(dlon); mb = {1'b0, k_q}; end
			ST_UNC_M:  begin ma = MA_W'($signed({1'b0, p_q})); mb = {1'b0, k_c}; end
			ST_Q12L_M: begin ma = MA_W'(mmi_est_q); mb = {2'b0, R12_LO}; end
			ST_Q12H_M: begin ma = MA_W'(mmi_est_q); mb = {2'b0, R12_HI}; end
			ST_Q10L_M: begin ma = MA_W'(mag_est_q); mb = {2'b0, R10_LO}; end
			ST_Q10H_M: begin ma = MA_W'(mag_est_q); mb = {2'b0, R10_HI}; end
			ST_ABL_M:  begin ma = MA_W'(a_q); mb = {1'b0, b_q[16:0]}; end
			ST_ABH_M:  begin ma = MA_W'(a_q); mb = MB_W'(b_q >>> 17); end
			ST_SC_M:   begin ma = sev_q; mb = conf; end
			default:   begin ma = '0; mb = '0; end
		endcase
	end

	// Quotient correction for floor division by 12 or 10, with EPS added
	logic signed [31:0] fix_x, fix_q, fix_res;
	logic signed [35:0] fix_qx, fix_qd, fix_r;
	logic               fix12;
	assign fix12   = (state_q == ST_Q12_FIX);
	assign fix_x   = fix12 ? mmi_est_q : mag_est_q;
	assign fix_q   = 32'(acc_q >>> RECIP_SH);
	assign fix_qx  = 36'(fix_q);
	assign fix_qd  = fix12 ? ((fix_qx <<< 3) + (fix_qx <<< 2))
	                       : ((fix_qx <<< 3) + (fix_qx <<< 1));
	assign fix_r   = 36'(fix_x) - fix_qd;
	assign fix_res = fix_q + $signed(EPS)
		+ (((fix12 && fix_r >= 36'sd12) || (!fix12 && fix_r >= 36'sd10)) ? 32'sd1 : 32'sd0);

	// Product scaling by 2^-16 and the gain inputs
	logic signed [MP_W-1:0] shr;
	assign shr = prod_q >>> FRAC;

	logic [P_W-1:0]   p_next;
	logic [DEN_W-1:0] r_sel;
	assign p_next = P_W'(uncert_q) + P_W'(pn_q);
	assign r_sel  = in_item.has_noise ? DEN_W'(in_item.noise) : DEN_W'(dn_q);

	// Register writes; an initial uncertainty write never reaches the filter
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pn_q <= PN_RESET;
			dn_q <= DN_RESET;
		end else if (cfg_we) begin
			case (cfg_idx)
				REG_PROCESS_NOISE: pn_q <= cfg_wdata[PN_W-1:0];
				REG_DEFAULT_NOISE: dn_q <= cfg_wdata;
				REG_INIT_UNCERT:   pn_q <= pn_q;
				default:           dn_q <= dn_q;
			endcase
		end
	end

	// Sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			mag_est_q   <= '0;
			mmi_est_q   <= '0;
			lat_est_q   <= '0;
			lon_est_q   <= '0;
			uncert_q    <= UNC_RESET;
			latest_q    <= '0;
			seen_q      <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			prod_q <= ma * mb;
			// Drop the result once taken, unless a new one replaces it
			if (out_valid_q && !out_stall && state_q != ST_OUT) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (in_valid) begin
						item_q <= in_item;
						late_q <= seen_q && (in_item.stamp_ms < latest_q);
						if (!seen_q || in_item.stamp_ms > latest_q) begin
							latest_q <= in_item.stamp_ms;
						end
						seen_q  <= 1'b1;
						p_q     <= p_next;
						den_q   <= DEN_W'(p_next) + r_sel;
						state_q <= ST_DIV_GO;
					end
				end
				ST_DIV_GO: state_q <= ST_DIV;
				ST_DIV: begin
					if (div_done) begin
						k_q     <= div_quo;
						state_q <= ST_MAG_M;
					end
				end
				ST_MAG_M: state_q <= ST_MAG_A;
				ST_MAG_A: begin
					if (item_q.has_mag) mag_est_q <= mag_est_q + READ_W'(shr);
					state_q <= ST_MMI_M;
				end
				ST_MMI_M: state_q <= ST_MMI_A;
				ST_MMI_A: begin
					if (item_q.has_mmi) mmi_est_q <= mmi_est_q + READ_W'(shr);
					state_q <= ST_LAT_M;
				end
				ST_LAT_M: state_q <= ST_LAT_A;
				ST_LAT_A: begin
					if (item_q.has_position) lat_est_q <= lat_est_q + POS_W'(shr);
					state_q <= ST_LON_M;
				end
				ST_LON_M: state_q <= ST_LON_A;
				ST_LON_A: begin
					if (item_q.has_position) lon_est_q <= lon_est_q + POS_W'(shr);
					state_q <= ST_UNC_M;
				end
				ST_UNC_M: state_q <= ST_UNC_A;
				ST_UNC_A: begin
					// Saturate the new uncertainty
					uncert_q <= (shr > MP_W'($signed({1'b0, UNC_MAX}))) ? UNC_MAX
						: UNC_W'(shr);
					state_q <= ST_Q12L_M;
				end
				ST_Q12L_M: state_q <= ST_Q12L_A;
				ST_Q12L_A: begin
					acc_q   <= ACC_W'(prod_q);
					state_q <= ST_Q12H_M;
				end
				ST_Q12H_M: state_q <= ST_Q12H_A;
				ST_Q12H_A: begin
					acc_q   <= acc_q + (ACC_W'(prod_q) <<< 16);
					state_q <= ST_Q12_FIX;
				end
				ST_Q12_FIX: begin
					a_q     <= fix_res;
					state_q <= ST_Q10L_M;
				end
				ST_Q10L_M: state_q <= ST_Q10L_A;
				ST_Q10L_A: begin
					acc_q   <= ACC_W'(prod_q);
					state_q <= ST_Q10H_M;
				end
				ST_Q10H_M: state_q <= ST_Q10H_A;
				ST_Q10H_A: begin
					acc_q   <= acc_q + (ACC_W'(prod_q) <<< 16);
					state_q <= ST_Q10_FIX;
				end
				ST_Q10_FIX: begin
					b_q     <= fix_res;
					state_q <= ST_ABL_M;
				end
				ST_ABL_M: state_q <= ST_ABL_A;
				ST_ABL_A: begin
					acc_q   <= ACC_W'(prod_q);
					state_q <= ST_ABH_M;
				end
				ST_ABH_M: state_q <= ST_ABH_A;
				ST_ABH_A: begin
					sev_q   <= MA_W'((acc_q + (ACC_W'(prod_q) <<< 17)) >>> FRAC);
					state_q <= ST_SC_M;
				end
				ST_SC_M: state_q <= ST_SC_A;
				ST_SC_A: begin
					// Clamp the score to the unsigned range
					if (shr < 0) begin
						score_q <= '0;
					end else if (shr > MP_W'($signed({1'b0, UNC_MAX}))) begin
						score_q <= UNC_MAX;
					end else begin
						score_q <= UNC_W'(shr);
					end
					state_q <= ST_OUT;
				end
				ST_OUT: begin
					// Hold until the output register is free
					if (!out_valid_q || !out_stall) begin
						out_q.mag_estimate    <= mag_est_q;
						out_q.mmi_estimate    <= mmi_est_q;
						out_q.lat_estimate    <= lat_est_q;
						out_q.lon_estimate    <= lon_est_q;
						out_q.uncertainty_out <= uncert_q;
						out_q.severity_score  <= score_q;
						out_q.late_flag       <= late_q;
						out_valid_q           <= 1'b1;
						state_q               <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	assign in_stall  = (state_q != ST_IDLE);
	assign out_valid = out_valid_q;
	assign out_item  = out_q;

endmodule

// ===== sim/kef_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// kef_checker
// Watches the request and result channels of the event fuser, keeps its own
// filter state and register copies, predicts each result and compares it
// field by field with what the block returns.
// ----------------------------------------------------------------------------
module kef_checker (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          in_valid,
	input  logic          in_stall,
	input  kef_pkg::in_t  in_item,
	input  logic          out_valid,
	input  logic          out_stall,
	input  kef_pkg::out_t out_item,
	input  logic          cfg_we,
	input  logic [kef_pkg::CFG_IDX_W-1:0] cfg_idx,
	input  logic [kef_pkg::CFG_W-1:0]     cfg_wdata,
	output int            fail_count,
	output int            pending
);
	import kef_pkg::*;

	localparam longint ONE_L = 64'sd65536;
	localparam longint UMAX_L = 64'sd131071;
	localparam longint EPS_L = 64'sd655;

	longint pnoise_q, dnoise_q;
	longint mag_q, mmi_q, lat_q, lon_q, unc_q;
	logic [STAMP_W-1:0] newest_stamp;
	logic stamp_seen;
	out_t fused_q[$];

	// floor division by a positive divisor
	function automatic longint floor_div(longint v, longint d);
		longint q;
		q = v / d;
		if (v < 0 && q * d != v) q--;
		return q;
	endfunction

	function automatic longint pull(longint est, longint z, longint k);
		return est + floor_div(k * (z - est), ONE_L);
	endfunction

	// predict one fused result and advance the filter state
	function automatic out_t fuse(in_t r);
		out_t o;
		longint p, rn, den, k, nu, a, b, sev, conf, score;
		o.late_flag = stamp_seen && (r.stamp_ms < newest_stamp);
		if (!stamp_seen || r.stamp_ms > newest_stamp) newest_stamp = r.stamp_ms;
		stamp_seen = 1'b1;
		p = unc_q + pnoise_q;
		rn = r.has_noise ? longint'(r.noise) : dnoise_q;
		den = p + rn;
		k = (den == 0) ? 0 : (p * ONE_L) / den;
		if (r.has_mag) mag_q = pull(mag_q, longint'(signed'(r.mag_reading)), k);
		if (r.has_mmi) mmi_q = pull(mmi_q, longint'(signed'(r.mmi_reading)), k);
		if (r.has_position) begin
			lat_q = pull(lat_q, longint'(signed'(r.lat_reading)), k);
			lon_q = pull(lon_q, longint'(signed'(r.lon_reading)), k);
		end
		nu = floor_div((ONE_L - k) * p, ONE_L);
		unc_q = (nu > UMAX_L) ? UMAX_L : nu;
		a = floor_div(mmi_q, 12) + EPS_L;
		b = floor_div(mag_q, 10) + EPS_L;
		sev = floor_div(a * b, ONE_L);
		conf = ONE_L - ((unc_q < ONE_L) ? unc_q : ONE_L);
		score = floor_div(sev * conf, ONE_L);
		if (score < 0) score = 0;
		if (score > UMAX_L) score = UMAX_L;
		o.mag_estimate = mag_q[31:0];
		o.mmi_estimate = mmi_q[31:0];
		o.lat_estimate = lat_q[24:0];
		o.lon_estimate = lon_q[24:0];
		o.uncertainty_out = unc_q[16:0];
		o.severity_score = score[16:0];
		return o;
	endfunction

	task automatic report(string what, logic [63:0] got, logic [63:0] want);
		$display("%0t mismatch %s: got %0h, want %0h", $realtime, what, got, want);
		fail_count++;
	endtask

	assign pending = fused_q.size();

	always @(posedge clk or negedge arst_n) begin
		out_t e;
		if (!arst_n) begin
			pnoise_q = 328;
			dnoise_q = 32768;
			mag_q = 0; mmi_q = 0; lat_q = 0; lon_q = 0;
			unc_q = 65536;
			newest_stamp = '0;
			stamp_seen = 1'b0;
			fused_q.delete();
			fail_count = 0;
		end else begin
			// register writes; an initial uncertainty write has no effect
			if (cfg_we) begin
				case (cfg_idx)
					REG_PROCESS_NOISE: pnoise_q = longint'(cfg_wdata[15:0]);
					REG_DEFAULT_NOISE: dnoise_q = longint'(cfg_wdata);
					default: ;
				endcase
			end
			// compare the oldest prediction with each accepted result
			if (out_valid && !out_stall) begin
				if (fused_q.size() == 0) begin
					report("unexpected result", 64'(out_item.mag_estimate), 64'(0));
				end else begin
					e = fused_q.pop_front();
					if (out_item.mag_estimate !== e.mag_estimate)
						report("mag_estimate", 64'(out_item.mag_estimate),
							64'(e.mag_estimate));
					if (out_item.mmi_estimate !== e.mmi_estimate)
						report("mmi_estimate", 64'(out_item.mmi_estimate),
							64'(e.mmi_estimate));
					if (out_item.lat_estimate !== e.lat_estimate)
						report("lat_estimate", 64'(out_item.lat_estimate),
							64'(e.lat_estimate));
					if (out_item.lon_estimate !== e.lon_estimate)
						report("lon_estimate", 64'(out_item.lon_estimate),
							64'(e.lon_estimate));
					if (out_item.uncertainty_out !== e.uncertainty_out)
						report("uncertainty_out", 64'(out_item.uncertainty_out),
							64'(e.uncertainty_out));
					if (out_item.severity_score !== e.severity_score)
						report("severity_score", 64'(out_item.severity_score),
							64'(e.severity_score));
					if (out_item.late_flag !== e.late_flag)
						report("late_flag", 64'(out_item.late_flag), 64'(e.late_flag));
				end
			end
			// queue the prediction for each accepted request
			if (in_valid && !in_stall) fused_q = {fused_q, fuse(in_item)};
		end
	end
endmodule

// ===== sim/scalar_kalman_event_fuser_top_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// scalar_kalman_event_fuser_top_tb
// Drives directed and random measurement requests through the event fuser
// under bursty input and random output stalls, walks the registers through
// several settings and reports the checker's verdict.
// ----------------------------------------------------------------------------
module scalar_kalman_event_fuser_top_tb;
	import kef_pkg::*;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic in_valid = 1'b0;
	logic in_stall;
	in_t in_item = '0;
	logic out_valid;
	logic out_stall = 1'b0;
	out_t out_item;
	logic cfg_we = 1'b0;
	logic [CFG_IDX_W-1:0] cfg_idx = REG_PROCESS_NOISE;
	logic [CFG_W-1:0] cfg_wdata = '0;
	int fail_count, pending;
	int hold_off = 0;
	int burst_left = 0;
	logic [STAMP_W-1:0] clock_ms = '0;

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	scalar_kalman_event_fuser_top dut (.*);

	kef_checker checker_i (.*);

	// receiver stall pattern, with a long hold-off when requested
	always @(posedge clk) begin
		if (hold_off > 0) begin
			out_stall <= 1'b1;
			hold_off <= hold_off - 1;
		end else begin
			case ($urandom_range(0, 3))
				0: out_stall <= 1'b0;
				1: out_stall <= ($urandom_range(0, 3) == 0);
				default: out_stall <= ($urandom_range(0, 1) == 0);
			endcase
		end
	end

	task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] val);
		@(posedge clk);
		cfg_we <= 1'b1;
		cfg_idx <= idx;
		cfg_wdata <= val;
		@(posedge clk);
		cfg_we <= 1'b0;
	endtask

	// offer one request and hold it until taken; random gap between bursts
	task automatic send(in_t r);
		if (burst_left == 0) begin
			repeat ($urandom_range(0, 60)) @(posedge clk);
			burst_left = $urandom_range(1, 12);
		end
		burst_left--;
		@(posedge clk);
		in_valid <= 1'b1;
		in_item <= r;
		do @(posedge clk); while (in_stall);
		in_valid <= 1'b0;
	endtask

	function automatic logic [POS_W-1:0] rand_pos();
		if ($urandom_range(0, 7) == 0) return POS_W'($urandom);
		return POS_W'($signed($urandom_range(0, 23592960)) - 32'sd11796480);
	endfunction

	function automatic logic [31:0] rand_read();
		case ($urandom_range(0, 3))
			0: return $urandom;
			1: return $urandom_range(0, 10 * 65536);
			2: return 32'($signed($urandom_range(0, 20 * 65536)) - 32'sd655360);
			default: return $urandom_range(0, 1) ? 32'h7fffffff : 32'h80000000;
		endcase
	endfunction

	function automatic in_t rand_req();
		in_t r;
		r.stamp_ms = ($urandom_range(0, 9) == 0) ? STAMP_W'({$urandom, $urandom}) :
			clock_ms + $urandom_range(0, 200) - 20;
		if (r.stamp_ms > clock_ms && r.stamp_ms - clock_ms < 1000) clock_ms = r.stamp_ms;
		r.has_noise = ($urandom_range(0, 1) == 1);
		r.noise = ($urandom_range(0, 3) == 0) ? NOISE_W'($urandom)
			: NOISE_W'($urandom_range(0, 131072));
		r.has_mag = $urandom_range(0, 3) != 0;
		r.mag_reading = rand_read();
		r.has_mmi = $urandom_range(0, 3) != 0;
		r.mmi_reading = rand_read();
		r.has_position = $urandom_range(0, 2) != 0;
		r.lat_reading = rand_pos();
		r.lon_reading = rand_pos();
		return r;
	endfunction

	// wait for every result, then for the block to settle
	task automatic drain();
		while (pending != 0) @(posedge clk);
		repeat (60) @(posedge clk);
	endtask

	initial begin
		in_t r;
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: extremes, each optional reading, late stamp, zero denominator
		write_reg(REG_INIT_UNCERT, 20'd131071);
		r = '0; r.stamp_ms = 1000; r.has_mag = 1; r.mag_reading = 32'h7fffffff;
		r.has_mmi = 1; r.mmi_reading = 32'h7fffffff; send(r);
		r.stamp_ms = 500; r.mag_reading = 32'h80000000; r.mmi_reading = 32'h80000000;
		send(r);
		r = '0; r.stamp_ms = '1; r.has_position = 1;
		r.lat_reading = 25'sd11796480; r.lon_reading = -25'sd11796480; send(r);
		r.lat_reading = 25'h1000000; r.lon_reading = 25'h0ffffff; send(r);
		r = '0; r.stamp_ms = '1; r.has_noise = 1; r.noise = '1; r.has_mag = 1;
		r.mag_reading = 32'd655360; r.has_mmi = 1; r.mmi_reading = 32'd786432;
		send(r);
		r.noise = '0; send(r);
		r.stamp_ms = 0; r.has_noise = 0; send(r);
		drain();
		// zero denominator: no process noise, no default noise, uncertainty driven to 0
		write_reg(REG_PROCESS_NOISE, 20'd0);
		write_reg(REG_DEFAULT_NOISE, 20'd0);
		repeat (4) begin
			r = rand_req(); r.has_noise = 0; send(r);
		end
		drain();

		// random phases across register settings
		for (int ph = 0; ph < 6; ph++) begin
			case (ph)
				0: begin write_reg(REG_PROCESS_NOISE, 20'd328);
					write_reg(REG_DEFAULT_NOISE, 20'd32768); end
				1: begin write_reg(REG_PROCESS_NOISE, 20'h0ffff);
					write_reg(REG_DEFAULT_NOISE, 20'hfffff); end
				2: begin write_reg(REG_PROCESS_NOISE, 20'd0);
					write_reg(REG_DEFAULT_NOISE, 20'd1); end
				3: write_reg(REG_INIT_UNCERT, 20'd0);
				default: begin write_reg(REG_PROCESS_NOISE, CFG_W'($urandom));
					write_reg(REG_DEFAULT_NOISE, CFG_W'($urandom)); end
			endcase
			if (ph == 2) hold_off = 2000;
			repeat (155) send(rand_req());
			drain();
		end

		if (fail_count == 0)
			$display("== PASS ==");
		else
			$display("== FAIL ==");
		$finish;
	end

	initial begin
		#20ms;
		$display("== FAIL ==");
		$finish;
	end
endmodule

// ===== filelist.f =====
rtl/core/kef_pkg.sv
rtl/core/kef_div.sv
rtl/core/scalar_kalman_event_fuser_top.sv
sim/kef_checker.sv
sim/scalar_kalman_event_fuser_top_tb.sv
